### hdl/vertex_world_transform_bounds_unit_assert.svh
// Assertion macros used by the vertex world transform back end.
`ifndef VERTEX_WORLD_TRANSFORM_BOUNDS_UNIT_ASSERT_SVH
`define VERTEX_WORLD_TRANSFORM_BOUNDS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VWTB_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VWTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vwtb_pkg.sv
// Shared types, constants and helpers of the vertex world transform block.
package vwtb_pkg;

  localparam int MAP_SPAN  = 40960;
  localparam int FRAC_BITS = 12;

  localparam int VTX_W    = 16;
  localparam int ROT_W    = 16;
  localparam int PROD_W   = VTX_W + ROT_W;
  localparam int ROW_W    = 3 * ROT_W;
  localparam int OFS_W    = 32;
  localparam int GRID_W   = 8;
  localparam int WORLD_W  = 48;
  // offset plus span times grid position, with headroom for the largest span
  localparam int TRANS_W  = OFS_W + 2;
  // translation scaled by the fraction bits plus dot product plus negate headroom
  localparam int SUM_W    = TRANS_W + 16 + 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W    = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [TRANS_W-1:0] SPAN = TRANS_W'(MAP_SPAN);
  localparam logic signed [WORLD_W-1:0] WORLD_MAX = {1'b0, {(WORLD_W-1){1'b1}}};
  localparam logic signed [WORLD_W-1:0] WORLD_MIN = {1'b1, {(WORLD_W-1){1'b0}}};

  localparam logic [ROW_W-1:0] ROT_ROW_ZERO_RST = 48'h0010_0000_0000;
  localparam logic [ROW_W-1:0] ROT_ROW_ONE_RST  = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0] ROT_ROW_TWO_RST  = 48'h0000_0000_1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW_ZERO = 4'd0,
    REG_ROT_ROW_ONE  = 4'd1,
    REG_ROT_ROW_TWO  = 4'd2,
    REG_OFFSET_X     = 4'd3,
    REG_OFFSET_Y     = 4'd4,
    REG_OFFSET_Z     = 4'd5,
    REG_GRID_COLUMN  = 4'd6,
    REG_GRID_ROW     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0]         rot_row_zero;
    logic [ROW_W-1:0]         rot_row_one;
    logic [ROW_W-1:0]         rot_row_two;
    logic signed [OFS_W-1:0]  offset_x;
    logic signed [OFS_W-1:0]  offset_y;
    logic signed [OFS_W-1:0]  offset_z;
    logic signed [GRID_W-1:0] grid_column;
    logic signed [GRID_W-1:0] grid_row;
  } cfg_t;

  typedef struct packed {
    logic signed [VTX_W-1:0] vertex_x;
    logic signed [VTX_W-1:0] vertex_y;
    logic signed [VTX_W-1:0] vertex_z;
    logic                    first_of_object;
  } in_item_t;

  typedef struct packed {
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic                      first_of_object;
  } queue_item_t;

  typedef struct packed {
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic signed [WORLD_W-1:0] box_min_x;
    logic signed [WORLD_W-1:0] box_min_y;
    logic signed [WORLD_W-1:0] box_min_z;
    logic signed [WORLD_W-1:0] box_max_x;
    logic signed [WORLD_W-1:0] box_max_y;
    logic signed [WORLD_W-1:0] box_max_z;
  } out_item_t;

  // Clamp a wide sum to the signed world range.
  function automatic logic signed [WORLD_W-1:0] sat_world(input logic signed [SUM_W-1:0] v);
    logic signed [WORLD_W-1:0] r;
    if (v > SUM_W'(WORLD_MAX)) begin
      r = WORLD_MAX;
    end else if (v < SUM_W'(WORLD_MIN)) begin
      r = WORLD_MIN;
    end else begin
      r = v[WORLD_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/vwtb_front.sv
// Front end: accept vertices, multiply by the rotation, add placement, push world points.
module vwtb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  vwtb_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vwtb_pkg::in_item_t    in_item,
  output logic                  push_valid,
  input  logic                  push_ready,
  output vwtb_pkg::queue_item_t push_item
);

  // stage 1: products and translation
  logic                                  s1_valid;
  logic signed [vwtb_pkg::PROD_W-1:0]    prod [3][3];
  logic signed [vwtb_pkg::PROD_W-1:0]    prod_next [3][3];
  logic signed [vwtb_pkg::TRANS_W-1:0]   trans [3];
  logic signed [vwtb_pkg::TRANS_W-1:0]   trans_next [3];
  logic                                  s1_first;
  // stage 2: saturated world point
  logic                                  s2_valid;
  vwtb_pkg::queue_item_t                 s2_item;
  vwtb_pkg::queue_item_t                 s2_item_next;

  logic [2:0][vwtb_pkg::ROW_W-1:0]       rows;
  logic signed [vwtb_pkg::VTX_W-1:0]     vtx [3];
  logic signed [vwtb_pkg::SUM_W-1:0]     sum [3];
  logic                                  s2_ready;
  logic                                  s1_ready;

  assign rows = {cfg.rot_row_two, cfg.rot_row_one, cfg.rot_row_zero};

  always_comb begin
    vtx[0] = in_item.vertex_x;
    vtx[1] = in_item.vertex_y;
    vtx[2] = in_item.vertex_z;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_next[r][c] = $signed(rows[r][vwtb_pkg::ROW_W-1-vwtb_pkg::ROT_W*c -:
                                          vwtb_pkg::ROT_W]) * vtx[c];
      end
    end
    trans_next[0] = vwtb_pkg::TRANS_W'(cfg.offset_x)
                  + vwtb_pkg::SPAN * vwtb_pkg::TRANS_W'(cfg.grid_column);
    trans_next[1] = vwtb_pkg::TRANS_W'(cfg.offset_y);
    trans_next[2] = vwtb_pkg::TRANS_W'(cfg.offset_z)
                  + vwtb_pkg::SPAN * vwtb_pkg::TRANS_W'(cfg.grid_row);
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = vwtb_pkg::SUM_W'(prod[r][0]) + vwtb_pkg::SUM_W'(prod[r][1])
             + vwtb_pkg::SUM_W'(prod[r][2])
             + (vwtb_pkg::SUM_W'(trans[r]) <<< vwtb_pkg::FRAC_BITS);
    end
    // y and z flip sign
    s2_item_next.world_x         = vwtb_pkg::sat_world(sum[0]);
    s2_item_next.world_y         = vwtb_pkg::sat_world(-sum[1]);
    s2_item_next.world_z         = vwtb_pkg::sat_world(-sum[2]);
    s2_item_next.first_of_object = s1_first;
  end

  assign s2_ready   = !s2_valid || push_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign in_ready   = s1_ready;
  assign push_valid = s2_valid;
  assign push_item  = s2_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      prod     <= prod_next;
      trans    <= trans_next;
      s1_first <= in_item.first_of_object;
    end
    if (s1_valid && s2_ready) begin
      s2_item <= s2_item_next;
    end
  end

endmodule

### hdl/vwtb_queue.sv
// Short queue of world points between the front and back ends.
module vwtb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  vwtb_pkg::queue_item_t push_item,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output vwtb_pkg::queue_item_t pop_item
);

  vwtb_pkg::queue_item_t           slots [vwtb_pkg::QUEUE_DEPTH];
  logic [vwtb_pkg::QPTR_W-1:0]     wr_ptr;
  logic [vwtb_pkg::QPTR_W-1:0]     rd_ptr;
  logic [vwtb_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = count != vwtb_pkg::QCNT_W'(vwtb_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == vwtb_pkg::QPTR_W'(vwtb_pkg::QUEUE_DEPTH - 1)) ? '0
                : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == vwtb_pkg::QPTR_W'(vwtb_pkg::QUEUE_DEPTH - 1)) ? '0
                : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### hdl/vwtb_back.sv
// Back end: update the running bounding box and hold the result.
`include "vertex_world_transform_bounds_unit_assert.svh"

module vwtb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  vwtb_pkg::queue_item_t pop_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vwtb_pkg::out_item_t   out_item
);

  logic signed [vwtb_pkg::WORLD_W-1:0] lo [3];
  logic signed [vwtb_pkg::WORLD_W-1:0] hi [3];
  logic signed [vwtb_pkg::WORLD_W-1:0] lo_next [3];
  logic signed [vwtb_pkg::WORLD_W-1:0] hi_next [3];
  logic signed [vwtb_pkg::WORLD_W-1:0] w [3];
  vwtb_pkg::out_item_t                 out_item_next;
  logic                                take;
  logic                                box_ok;
  logic                                world_ok;
  logic                                corner_ok;
  logic                                restart_take;
  logic                                restart_ok;

  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    w[0] = pop_item.world_x;
    w[1] = pop_item.world_y;
    w[2] = pop_item.world_z;
    for (int a = 0; a < 3; a++) begin
      if (pop_item.first_of_object) begin
        lo_next[a] = w[a];
        hi_next[a] = w[a];
      end else begin
        lo_next[a] = (w[a] < lo[a]) ? w[a] : lo[a];
        hi_next[a] = (w[a] > hi[a]) ? w[a] : hi[a];
      end
    end
    out_item_next.world_x   = w[0];
    out_item_next.world_y   = w[1];
    out_item_next.world_z   = w[2];
    out_item_next.box_min_x = lo_next[0];
    out_item_next.box_min_y = lo_next[1];
    out_item_next.box_min_z = lo_next[2];
    out_item_next.box_max_x = hi_next[0];
    out_item_next.box_max_y = hi_next[1];
    out_item_next.box_max_z = hi_next[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        lo[a] <= vwtb_pkg::WORLD_MAX;
        hi[a] <= vwtb_pkg::WORLD_MIN;
      end
    end else begin
      if (pop_ready) begin
        out_valid <= pop_valid;
      end
      if (take) begin
        lo <= lo_next;
        hi <= hi_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= out_item_next;
    end
  end

  always_comb begin
    box_ok = (out_item.box_min_x <= out_item.box_max_x)
          && (out_item.box_min_y <= out_item.box_max_y)
          && (out_item.box_min_z <= out_item.box_max_z);
    world_ok = (out_item.world_x >= out_item.box_min_x)
            && (out_item.world_x <= out_item.box_max_x)
            && (out_item.world_y >= out_item.box_min_y)
            && (out_item.world_y <= out_item.box_max_y)
            && (out_item.world_z >= out_item.box_min_z)
            && (out_item.world_z <= out_item.box_max_z);
    corner_ok = (out_item.box_min_x == lo[0]) && (out_item.box_max_z == hi[2]);
    restart_take = take && pop_item.first_of_object;
    restart_ok = (out_item.box_min_y == out_item.world_y)
              && (out_item.box_max_y == out_item.world_y);
  end

  `VWTB_ASSERT(a_box_ordered, clk, rst, out_valid, box_ok, "box corners out of order")
  `VWTB_ASSERT(a_world_in_box, clk, rst, out_valid, world_ok, "world point outside box")
  `VWTB_ASSERT(a_corner_held, clk, rst, out_valid, corner_ok, "held box differs from corners")
  `VWTB_ASSERT_NEXT(a_restart, clk, rst, restart_take, restart_ok, "box did not restart")

endmodule

### hdl/vertex_world_transform_bounds_unit.sv
// Top level of the vertex world transform and bounding box unit.
// Usage:
//   Write the rotation rows, offsets and grid position through cfg_we /
//   cfg_index / cfg_data while the block is idle; indexes above the last
//   register are ignored, and each register keeps only its low bits.
//   Vertices arrive on in_valid / in_ready / in_item, one transaction each;
//   every vertex yields exactly one transaction on out_valid / out_ready /
//   out_item with its world point and the object's box after that vertex.
//   Path: a vertex passes the two front stages, the queue and the output
//   register before it can be taken on out_valid / out_ready.
//   Throughput: one vertex per cycle, set by the nine 16x16 multipliers in
//   the first front stage and the single-compare box update in the back end.
//   Stall: when out_ready is low the output register holds; the back end
//   stops popping, the 4-entry queue fills, then the front stages hold and
//   in_ready drops. Nothing is lost or repeated.
//   Reset (rst, synchronous): configuration returns to its reset rotation
//   with zero placement, all stages and the queue empty, and the box corners
//   go to the extremes so the first vertex sets both corners.
module vertex_world_transform_bounds_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vwtb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vwtb_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vwtb_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vwtb_pkg::out_item_t                 out_item
);

  vwtb_pkg::cfg_t        cfg;
  logic                  push_valid;
  logic                  push_ready;
  vwtb_pkg::queue_item_t push_item;
  logic                  pop_valid;
  logic                  pop_ready;
  vwtb_pkg::queue_item_t pop_item;

  // Configuration registers: write only, truncate to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_row_zero <= vwtb_pkg::ROT_ROW_ZERO_RST;
      cfg.rot_row_one  <= vwtb_pkg::ROT_ROW_ONE_RST;
      cfg.rot_row_two  <= vwtb_pkg::ROT_ROW_TWO_RST;
      cfg.offset_x     <= '0;
      cfg.offset_y     <= '0;
      cfg.offset_z     <= '0;
      cfg.grid_column  <= '0;
      cfg.grid_row     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vwtb_pkg::REG_ROT_ROW_ZERO: cfg.rot_row_zero <= cfg_data[vwtb_pkg::ROW_W-1:0];
        vwtb_pkg::REG_ROT_ROW_ONE:  cfg.rot_row_one  <= cfg_data[vwtb_pkg::ROW_W-1:0];
        vwtb_pkg::REG_ROT_ROW_TWO:  cfg.rot_row_two  <= cfg_data[vwtb_pkg::ROW_W-1:0];
        vwtb_pkg::REG_OFFSET_X:     cfg.offset_x     <= cfg_data[vwtb_pkg::OFS_W-1:0];
        vwtb_pkg::REG_OFFSET_Y:     cfg.offset_y     <= cfg_data[vwtb_pkg::OFS_W-1:0];
        vwtb_pkg::REG_OFFSET_Z:     cfg.offset_z     <= cfg_data[vwtb_pkg::OFS_W-1:0];
        vwtb_pkg::REG_GRID_COLUMN:  cfg.grid_column  <= cfg_data[vwtb_pkg::GRID_W-1:0];
        vwtb_pkg::REG_GRID_ROW:     cfg.grid_row     <= cfg_data[vwtb_pkg::GRID_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Front end: rotate and place each vertex, push the world point.
  vwtb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decouple the transform pipeline from the output stall.
  vwtb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back end: advance the bounding box and hold the result for the receiver.
  vwtb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench for the vertex world transform and bounding box unit.
module tb;

  localparam longint WORLD_TOP = (longint'(1) <<< (vwtb_pkg::WORLD_W - 1)) - 1;
  localparam longint WORLD_BOTTOM = -(longint'(1) <<< (vwtb_pkg::WORLD_W - 1));
  // No transaction on either side for this many cycles means the block hung.
  localparam int HANG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_VERTICES = 155;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [vwtb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vwtb_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  vwtb_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vwtb_pkg::out_item_t out_item;

  vertex_world_transform_bounds_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always #6 clk = ~clk;

  // Shadow of the block's registers and running box, kept in step with the
  // transactions the block accepts.
  vwtb_pkg::cfg_t placement = '{
    rot_row_zero: vwtb_pkg::ROT_ROW_ZERO_RST,
    rot_row_one: vwtb_pkg::ROT_ROW_ONE_RST,
    rot_row_two: vwtb_pkg::ROT_ROW_TWO_RST,
    offset_x: '0,
    offset_y: '0,
    offset_z: '0,
    grid_column: '0,
    grid_row: '0
  };
  longint box_low[3] = '{WORLD_TOP, WORLD_TOP, WORLD_TOP};
  longint box_high[3] = '{WORLD_BOTTOM, WORLD_BOTTOM, WORLD_BOTTOM};

  vwtb_pkg::in_item_t model_vertices_q[$];   // vertices waiting for the driver
  vwtb_pkg::out_item_t world_points_q[$];    // predicted points and boxes, oldest first

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int vertices_sent = 0;
  int points_seen = 0;
  int box_restarts = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  string field_names[9] = '{"world_x", "world_y", "world_z", "box_min_x", "box_min_y",
                            "box_min_z", "box_max_x", "box_max_y", "box_max_z"};

  function automatic longint row_dot(logic [vwtb_pkg::ROW_W-1:0] row, longint px,
                                     longint py, longint pz);
    longint a, b, c;
    a = $signed(row[47:32]);
    b = $signed(row[31:16]);
    c = $signed(row[15:0]);
    return a * px + b * py + c * pz;
  endfunction

  function automatic longint clamp_world(longint v);
    if (v > WORLD_TOP) return WORLD_TOP;
    if (v < WORLD_BOTTOM) return WORLD_BOTTOM;
    return v;
  endfunction

  // Rotate and place one vertex, then fold it into the running box.
  function automatic vwtb_pkg::out_item_t place_vertex(vwtb_pkg::in_item_t v);
    longint px, py, pz, scale, shift_x, shift_y, shift_z;
    longint pos[3];
    vwtb_pkg::out_item_t r;
    px = $signed(v.vertex_x);
    py = $signed(v.vertex_y);
    pz = $signed(v.vertex_z);
    scale = longint'(1) <<< vwtb_pkg::FRAC_BITS;
    shift_x = ($signed(placement.offset_x) +
               longint'(vwtb_pkg::MAP_SPAN) * $signed(placement.grid_column)) * scale;
    shift_y = $signed(placement.offset_y) * scale;
    shift_z = ($signed(placement.offset_z) +
               longint'(vwtb_pkg::MAP_SPAN) * $signed(placement.grid_row)) * scale;
    // y and z come out negated: the world frame flips both axes
    pos[0] = clamp_world(row_dot(placement.rot_row_zero, px, py, pz) + shift_x);
    pos[1] = clamp_world(-(row_dot(placement.rot_row_one, px, py, pz) + shift_y));
    pos[2] = clamp_world(-(row_dot(placement.rot_row_two, px, py, pz) + shift_z));
    for (int k = 0; k < 3; k++) begin
      if (v.first_of_object) begin
        box_low[k] = pos[k];
        box_high[k] = pos[k];
      end else begin
        if (pos[k] < box_low[k]) box_low[k] = pos[k];
        if (pos[k] > box_high[k]) box_high[k] = pos[k];
      end
    end
    r.world_x = pos[0][vwtb_pkg::WORLD_W-1:0];
    r.world_y = pos[1][vwtb_pkg::WORLD_W-1:0];
    r.world_z = pos[2][vwtb_pkg::WORLD_W-1:0];
    r.box_min_x = box_low[0][vwtb_pkg::WORLD_W-1:0];
    r.box_min_y = box_low[1][vwtb_pkg::WORLD_W-1:0];
    r.box_min_z = box_low[2][vwtb_pkg::WORLD_W-1:0];
    r.box_max_x = box_high[0][vwtb_pkg::WORLD_W-1:0];
    r.box_max_y = box_high[1][vwtb_pkg::WORLD_W-1:0];
    r.box_max_z = box_high[2][vwtb_pkg::WORLD_W-1:0];
    return r;
  endfunction

  // Bias coordinates toward the range ends and toward zero now and then.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vwtb_pkg::in_item_t random_vertex(logic first);
    vwtb_pkg::in_item_t v;
    v.vertex_x = pick_coord();
    v.vertex_y = pick_coord();
    v.vertex_z = pick_coord();
    v.first_of_object = first;
    return v;
  endfunction

  function automatic logic [15:0] pick_rot_entry();
    case ($urandom_range(11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h1000;
      3: return 16'hF000;
      4: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] random_word();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  // Assert one register write; the caller closes the burst with close_writes.
  // The shadow copy keeps only the register's width, like the block.
  task automatic set_register(logic [vwtb_pkg::CFG_IDX_W-1:0] idx,
                              logic [vwtb_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      vwtb_pkg::REG_ROT_ROW_ZERO: placement.rot_row_zero = data[vwtb_pkg::ROW_W-1:0];
      vwtb_pkg::REG_ROT_ROW_ONE: placement.rot_row_one = data[vwtb_pkg::ROW_W-1:0];
      vwtb_pkg::REG_ROT_ROW_TWO: placement.rot_row_two = data[vwtb_pkg::ROW_W-1:0];
      vwtb_pkg::REG_OFFSET_X: placement.offset_x = data[vwtb_pkg::OFS_W-1:0];
      vwtb_pkg::REG_OFFSET_Y: placement.offset_y = data[vwtb_pkg::OFS_W-1:0];
      vwtb_pkg::REG_OFFSET_Z: placement.offset_z = data[vwtb_pkg::OFS_W-1:0];
      vwtb_pkg::REG_GRID_COLUMN: placement.grid_column = data[vwtb_pkg::GRID_W-1:0];
      vwtb_pkg::REG_GRID_ROW: placement.grid_row = data[vwtb_pkg::GRID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Hold until the driver is empty and every predicted point has come back,
  // then let the pipeline idle before returning.
  task automatic wait_drained();
    while (model_vertices_q.size() != 0 || in_valid || world_points_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Queue objects of random length: flag on the first vertex of each, with
  // a stray restart thrown in now and then.
  task automatic queue_objects(int count);
    int left;
    logic first;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 24);
        first = 1'b1;
      end else begin
        first = ($urandom_range(99) < 4);
      end
      left--;
      model_vertices_q = {model_vertices_q, random_vertex(first)};
    end
  endtask

  task automatic queue_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic first);
    vwtb_pkg::in_item_t v;
    v.vertex_x = x;
    v.vertex_y = y;
    v.vertex_z = z;
    v.first_of_object = first;
    model_vertices_q = {model_vertices_q, v};
  endtask

  // Driver: predict on every accepted transaction, then either hold the
  // current vertex or launch the next one, or idle.
  always @(posedge clk) begin
    logic holding;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        world_points_q = {world_points_q, place_vertex(in_item)};
        vertices_sent++;
        if (in_item.first_of_object) box_restarts++;
      end
      holding = in_valid && !in_ready;
      if (!holding) begin
        if (model_vertices_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= model_vertices_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction, field
  // by field, and toggle ready at random.
  always @(posedge clk) begin
    vwtb_pkg::out_item_t want;
    logic [9*vwtb_pkg::WORLD_W-1:0] got_bits, want_bits;
    logic [vwtb_pkg::WORLD_W-1:0] got_f, want_f;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        points_seen++;
        if (world_points_q.size() == 0) begin
          note_mismatch("result with no vertex outstanding");
        end else begin
          want = world_points_q.pop_front();
          got_bits = out_item;
          want_bits = want;
          for (int k = 0; k < 9; k++) begin
            got_f = got_bits[(8-k)*vwtb_pkg::WORLD_W +: vwtb_pkg::WORLD_W];
            want_f = want_bits[(8-k)*vwtb_pkg::WORLD_W +: vwtb_pkg::WORLD_W];
            if (got_f !== want_f)
              note_mismatch($sformatf("point %0d %s expected %0d got %0d", points_seen,
                field_names[k], $signed(want_f), $signed(got_f)));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Count cycles with no transaction of any kind.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < HANG_LIMIT) @(posedge clk);
    $display("tb: hang, no transaction for %0d cycles", HANG_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int modes_send[4];
    int modes_stall[4];
    modes_send = '{0, 75, 0, 37};
    modes_stall = '{0, 0, 75, 37};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset placement: reset rotation. The first vertex carries no
    // restart flag, so the reset corners must lose both compares.
    queue_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
    queue_vertex(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
    queue_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    queue_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_vertex(16'h0001, 16'h0002, 16'h0003, 1'b1);
    queue_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
    queue_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    wait_drained();

    // Largest positive matrix and placement.
    set_register(vwtb_pkg::REG_ROT_ROW_ZERO, 48'h7FFF_7FFF_7FFF);
    set_register(vwtb_pkg::REG_ROT_ROW_ONE, 48'h7FFF_7FFF_7FFF);
    set_register(vwtb_pkg::REG_ROT_ROW_TWO, 48'h7FFF_7FFF_7FFF);
    set_register(vwtb_pkg::REG_OFFSET_X, 48'h0000_7FFF_FFFF);
    set_register(vwtb_pkg::REG_OFFSET_Y, 48'h0000_7FFF_FFFF);
    set_register(vwtb_pkg::REG_OFFSET_Z, 48'h0000_7FFF_FFFF);
    set_register(vwtb_pkg::REG_GRID_COLUMN, 48'h0000_0000_007F);
    set_register(vwtb_pkg::REG_GRID_ROW, 48'h0000_0000_007F);
    close_writes();
    queue_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    queue_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
    queue_vertex(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
    queue_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
    queue_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
    queue_vertex(16'h1234, 16'hEDCB, 16'h0F0F, 1'b0);
    wait_drained();

    // Most negative values, with junk above the offset and grid registers'
    // widths, and two writes to unused indexes that must change nothing.
    set_register(vwtb_pkg::REG_ROT_ROW_ZERO, 48'h8000_8000_8000);
    set_register(vwtb_pkg::REG_ROT_ROW_ONE, 48'h8000_8000_8000);
    set_register(vwtb_pkg::REG_ROT_ROW_TWO, 48'h8000_8000_8000);
    set_register(vwtb_pkg::REG_OFFSET_X, 48'hFFFF_8000_0000);
    set_register(vwtb_pkg::REG_OFFSET_Y, 48'hA5A5_8000_0000);
    set_register(vwtb_pkg::REG_OFFSET_Z, 48'h5A5A_8000_0000);
    set_register(vwtb_pkg::REG_GRID_COLUMN, 48'hFFFF_FFFF_FF80);
    set_register(vwtb_pkg::REG_GRID_ROW, 48'h1234_5678_9A80);
    set_register(vwtb_pkg::CFG_IDX_W'(vwtb_pkg::REG_GRID_ROW + 1), 48'h7FFF_7FFF_7FFF);
    set_register(vwtb_pkg::CFG_IDX_W'(vwtb_pkg::REG_GRID_ROW + 8), 48'h1111_2222_3333);
    close_writes();
    queue_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
    queue_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_vertex(16'h0000, 16'h8000, 16'h7FFF, 1'b0);
    queue_vertex(16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
    queue_vertex(16'h4000, 16'hC000, 16'h0000, 1'b1);
    queue_vertex(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
    wait_drained();

    // Random placements, the phases cycling through four idling and stall patterns.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int r = vwtb_pkg::REG_ROT_ROW_ZERO; r <= vwtb_pkg::REG_ROT_ROW_TWO; r++)
        set_register(vwtb_pkg::CFG_IDX_W'(r),
                     {pick_rot_entry(), pick_rot_entry(), pick_rot_entry()});
      for (int r = vwtb_pkg::REG_OFFSET_X; r <= vwtb_pkg::REG_GRID_ROW; r++)
        set_register(vwtb_pkg::CFG_IDX_W'(r), ($urandom_range(5) == 0) ?
                     {16'($urandom), 32'h8000_0000 - 32'($urandom_range(1))} :
                     random_word());
      set_register(vwtb_pkg::CFG_IDX_W'(vwtb_pkg::REG_GRID_ROW + 1 + $urandom_range(7)),
                   random_word());
      close_writes();
      send_idle_pct = modes_send[phase % 4];
      stall_pct = modes_stall[phase % 4];
      queue_objects(PHASE_VERTICES / 2);
      // Sender pause: nothing new until every point so far is back.
      wait_drained();
      queue_objects(PHASE_VERTICES - PHASE_VERTICES / 2);
      wait_drained();
    end

    $display("summary: %0d vertices, %0d points checked, %0d box restarts, %0d placements",
             vertices_sent, points_seen, box_restarts, settings_used);
    if (mismatches == 0 && world_points_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/vwtb_pkg.sv
hdl/vwtb_front.sv
hdl/vwtb_queue.sv
hdl/vwtb_back.sv
hdl/vertex_world_transform_bounds_unit.sv
sim/tb.sv
